// File: sv/ghcb_pkg.sv
// ----------------------------------------------------------------------------
// ghcb_pkg: shared types and constants of the gear-hash chunker
// Word formats, operation codes, cut kinds and sizing constants.
// ----------------------------------------------------------------------------
package ghcb_pkg;

    localparam int MAX_CHUNK   = 65536;
    localparam int LANES       = 8;
    localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int LEN_W       = 17;
    localparam int MASK_W      = 5;
    localparam int GEAR_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = LEN_W;

    localparam logic [MASK_W-1:0] MASK_BITS_RST  = MASK_W'(13);
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = LEN_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_BITS  = 1'b0,
        CFG_MAX_LENGTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_BYTE = 2'd1,
        ACT_EOS  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_BYTE = 2'd1,
        OP_EOS  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CUT_HASH  = 2'd0,
        CUT_LIMIT = 2'd1,
        CUT_TAIL  = 2'd2
    } t_cut;

    // classified word handed from front to back
    typedef struct packed {
        t_op                 op;
        logic [BYTE_W-1:0]   addr;   // table index for loads, data byte otherwise
        logic [GEAR_W-1:0]   word;
    } t_cmd;

    typedef struct packed {
        logic [MASK_W-1:0] mask_bits;
        logic [LEN_W-1:0]  max_length;
    } t_cfg;

endpackage

// File: sv/ghcb_in_if.sv
// ----------------------------------------------------------------------------
// ghcb_in_if: input channel of the chunker
// Valid/ready channel carrying one table-load, data-byte or end-of-stream word.
// ----------------------------------------------------------------------------
interface ghcb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [7:0]  table_index;
    logic [31:0] table_word;

    modport source (output valid, action, data_byte, table_index, table_word,
                    input ready);
    modport sink   (input valid, action, data_byte, table_index, table_word,
                    output ready);
endinterface

// File: sv/ghcb_out_if.sv
// ----------------------------------------------------------------------------
// ghcb_out_if: result channel of the chunker
// Valid/ready channel carrying one chunk length and its cut kind per word.
// ----------------------------------------------------------------------------
interface ghcb_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] chunk_length;
    logic [1:0]  cut_kind;

    modport source (output valid, chunk_length, cut_kind, input ready);
    modport sink   (input valid, chunk_length, cut_kind, output ready);
endinterface

// File: sv/gear_hash_chunk_boundary.sv
// ----------------------------------------------------------------------------
// gear_hash_chunk_boundary: content-defined chunker on a gear rolling hash
// Top level: configuration registers, front stage, queue and hashing engine.
// ----------------------------------------------------------------------------
// Usage notes:
//   i_data  : valid/ready input words. action 0 writes table_word into gear
//             table entry table_index, 1 hashes data_byte, 2 ends the stream,
//             3 is dropped. Load every table entry before sending data bytes.
//   o_chunk : valid/ready result words, one per chunk end: chunk_length and
//             cut_kind (0 hash match, 1 max length reached, 2 stream tail).
//   cfg     : i_cfg_we writes i_cfg_data into register i_cfg_idx
//             (0 mask_bits, 1 max_length). Write only while the block is idle.
// Throughput: one word per cycle while results are taken, set by the lane update
//   (table read registered in the previous stage, then shift-add-compare).
// Path: an accepted word passes the front register, the queue, the table read
//   register and the lane update into the result register.
// Reset: synchronous, active low; clears lanes, offset, queue and handshake
//   state; mask_bits = 13, max_length = 65536. The gear table is not cleared.
// Stall: a held result stalls the engine; the 4-deep queue and the front
//   register keep accepting until full, then i_data.ready drops.
// ----------------------------------------------------------------------------
module gear_hash_chunk_boundary
    import ghcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ghcb_in_if.sink               i_data,
    ghcb_out_if.source            o_chunk
);

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_bits  <= MASK_BITS_RST;
            r_cfg.max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MASK_BITS:  r_cfg.mask_bits  <= i_cfg_data[MASK_W-1:0];
                CFG_MAX_LENGTH: r_cfg.max_length <= i_cfg_data[LEN_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // decode and register incoming words
    ghcb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd),
        .i_q_full (w_q_full)
    );

    // decouples input acceptance from engine stalls
    ghcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // table memory, lanes, cut decision and result register
    ghcb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_chunk     (o_chunk)
    );

endmodule

// File: sv/ghcb_front.sv
// ----------------------------------------------------------------------------
// ghcb_front: input stage
// Accepts words, decodes the action, drops unknown actions and registers a
// command for the queue.
// ----------------------------------------------------------------------------
module ghcb_front
    import ghcb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ghcb_in_if.sink      i_data,
    output logic         o_push,
    output t_cmd         o_cmd,
    input  logic         i_q_full
);

    logic    r_valid;
    t_cmd    r_cmd;
    t_cmd    n_cmd;
    logic    n_keep;
    logic    w_accept;
    t_action w_act;

    assign o_push       = r_valid && !i_q_full;
    assign i_data.ready = !r_valid || !i_q_full;
    assign w_accept     = i_data.valid && i_data.ready;
    assign w_act        = t_action'(i_data.action);
    assign o_cmd        = r_cmd;

    always_comb begin
        n_keep      = 1'b1;
        n_cmd.word  = i_data.table_word;
        n_cmd.addr  = i_data.data_byte;
        n_cmd.op    = OP_BYTE;
        case (w_act)
            ACT_LOAD: begin
                n_cmd.op   = OP_LOAD;
                n_cmd.addr = i_data.table_index;
            end
            ACT_BYTE: n_cmd.op = OP_BYTE;
            ACT_EOS:  n_cmd.op = OP_EOS;
            default:  n_keep = 1'b0;    // unknown action: swallowed here
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= n_keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: sv/ghcb_queue.sv
// ----------------------------------------------------------------------------
// ghcb_queue: command queue
// Small FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module ghcb_queue
    import ghcb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

// File: sv/ghcb_back.sv
// ----------------------------------------------------------------------------
// ghcb_back: hashing engine
// Gear table memory, fingerprint lanes, chunk offset, cut decision and the
// result register.
// ----------------------------------------------------------------------------
module ghcb_back
    import ghcb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_cmd_valid,
    input  t_cmd         i_cmd,
    output logic         o_pop,
    ghcb_out_if.source   o_chunk
);

    // stage A: table access
    logic [GEAR_W-1:0] r_gear_mem [TABLE_DEPTH];
    logic [GEAR_W-1:0] r_gear;

    // stage B: lane update and cut decision
    logic              r_b_valid;
    t_op               r_b_op;
    logic [GEAR_W-1:0] r_lanes [LANES];
    logic [LANE_W-1:0] r_lane;
    logic [LEN_W-1:0]  r_offset;

    // result register
    logic              r_o_valid;
    logic [LEN_W-1:0]  r_o_len;
    t_cut              r_o_kind;

    logic              w_b_fire;
    logic [GEAR_W-1:0] w_fp;
    logic [GEAR_W-1:0] w_mask;
    logic [LEN_W-1:0]  w_limit;
    logic [LEN_W-1:0]  w_next_off;
    logic              n_res;
    t_cut              n_kind;
    logic [LEN_W-1:0]  n_len;
    logic              n_clear;
    logic              n_step;

    assign w_b_fire = r_b_valid && (!r_o_valid || o_chunk.ready);
    assign o_pop    = i_cmd_valid && (!r_b_valid || w_b_fire);

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == OP_LOAD)) begin
            r_gear_mem[i_cmd.addr] <= i_cmd.word;
        end
        if (o_pop) begin
            r_gear <= r_gear_mem[i_cmd.addr];
        end
    end

    always_comb begin
        w_fp       = {r_lanes[r_lane][GEAR_W-2:0], 1'b0} + r_gear;
        w_mask     = (GEAR_W'(1) << i_cfg.mask_bits) - GEAR_W'(1);
        w_next_off = r_offset + 1'b1;
        if (i_cfg.max_length == '0) begin
            w_limit = LEN_W'(1);
        end else if (i_cfg.max_length > LEN_W'(MAX_CHUNK)) begin
            w_limit = LEN_W'(MAX_CHUNK);
        end else begin
            w_limit = i_cfg.max_length;
        end

        n_res   = 1'b0;
        n_kind  = CUT_HASH;
        n_len   = w_next_off;
        n_clear = 1'b0;
        n_step  = 1'b0;
        case (r_b_op)
            OP_BYTE: begin
                if ((w_fp & w_mask) == w_mask) begin
                    n_res   = 1'b1;
                    n_clear = 1'b1;
                end else if (w_next_off >= w_limit) begin
                    n_res   = 1'b1;
                    n_kind  = CUT_LIMIT;
                    n_clear = 1'b1;
                end else begin
                    n_step = 1'b1;
                end
            end
            OP_EOS: begin
                n_len  = r_offset;
                n_kind = CUT_TAIL;
                if (r_offset != '0) begin
                    n_res   = 1'b1;
                    n_clear = 1'b1;
                end
            end
            default: n_res = 1'b0;    // table load finished in stage A
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_op    <= OP_LOAD;
            r_lane    <= '0;
            r_offset  <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_lanes[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
                r_b_op    <= i_cmd.op;
            end else if (w_b_fire) begin
                r_b_valid <= 1'b0;
            end

            if (w_b_fire && n_clear) begin
                r_lane   <= '0;
                r_offset <= '0;
                for (int i = 0; i < LANES; i++) begin
                    r_lanes[i] <= '0;
                end
            end else if (w_b_fire && n_step) begin
                r_lanes[r_lane] <= w_fp;
                r_offset        <= w_next_off;
                r_lane          <= (r_lane == LANE_W'(LANES-1)) ? '0 : r_lane + 1'b1;
            end

            if (w_b_fire && n_res) begin
                r_o_valid <= 1'b1;
            end else if (o_chunk.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_fire && n_res) begin
            r_o_len  <= n_len;
            r_o_kind <= n_kind;
        end
    end

    assign o_chunk.valid        = r_o_valid;
    assign o_chunk.chunk_length = r_o_len;
    assign o_chunk.cut_kind     = r_o_kind;

    a_clear_after_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_fire && n_res) |=> (r_offset == '0) && (r_lane == '0))
        else $error("chunk state not cleared after cut");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset < LEN_W'(MAX_CHUNK))
        else $error("chunk offset reached maximum without cut");

    a_lane_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_lane) == (32'(r_offset) % LANES))
        else $error("lane index out of step with offset");

endmodule

// File: tb/sv/ghcb_chunk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ghcb_chunk_checker: chunk-boundary predictor and result checker
// Tracks the config port and every accepted input word, keeps its own gear
// table, lanes and chunk offset, and checks each chunk-end word in order.
// ----------------------------------------------------------------------------
module ghcb_chunk_checker
    import ghcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ghcb_in_if                    i_data,
    ghcb_out_if                   i_chunk,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic [LEN_W-1:0] length;
        t_cut             kind;
    } t_chunk_end;

    logic [GEAR_W-1:0] gear_copy [TABLE_DEPTH];
    logic [GEAR_W-1:0] lane_fp   [LANES];
    int unsigned       bytes_in_chunk;
    logic [MASK_W-1:0] mask_bits;
    logic [LEN_W-1:0]  max_length;
    t_chunk_end        chunk_ends_q [$];
    int                fails;

    // Applies one word to the shadow state; returns 1 when it closes a chunk.
    function automatic bit advance_stream(input t_action act, input logic [BYTE_W-1:0] dbyte,
                                          input logic [BYTE_W-1:0] tidx,
                                          input logic [GEAR_W-1:0] tword,
                                          output t_chunk_end cut);
        logic [GEAR_W-1:0] mask;
        logic [GEAR_W-1:0] fp;
        int unsigned       slot;
        int unsigned       limit;
        bit                closed;
        closed     = 1'b0;
        cut.length = '0;
        cut.kind   = CUT_HASH;
        case (act)
            ACT_LOAD: gear_copy[tidx] = tword;
            ACT_BYTE: begin
                slot  = bytes_in_chunk % LANES;
                mask  = (GEAR_W'(1) << mask_bits) - GEAR_W'(1);
                fp    = (lane_fp[slot] << 1) + gear_copy[dbyte];
                lane_fp[slot] = fp;
                bytes_in_chunk++;
                limit = 32'(max_length);
                if (limit == 0) limit = 1;
                if (limit > MAX_CHUNK) limit = MAX_CHUNK;
                // hash match wins over the length limit on the same byte
                if ((fp & mask) == mask) begin
                    closed   = 1'b1;
                    cut.kind = CUT_HASH;
                end else if (bytes_in_chunk >= limit) begin
                    closed   = 1'b1;
                    cut.kind = CUT_LIMIT;
                end
            end
            ACT_EOS: begin
                if (bytes_in_chunk != 0) begin
                    closed   = 1'b1;
                    cut.kind = CUT_TAIL;
                end
            end
            default: ;
        endcase
        if (closed) begin
            cut.length = LEN_W'(bytes_in_chunk);
            foreach (lane_fp[i]) lane_fp[i] = '0;
            bytes_in_chunk = 0;
        end
        return closed;
    endfunction

    always @(posedge i_clk) begin
        t_chunk_end want;
        t_chunk_end cut;
        if (!i_rst_n) begin
            foreach (lane_fp[i]) lane_fp[i] = '0;
            bytes_in_chunk = 0;
            mask_bits      = MASK_BITS_RST;
            max_length     = MAX_LENGTH_RST;
            chunk_ends_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MASK_BITS:  mask_bits  = i_cfg_data[MASK_W-1:0];
                    CFG_MAX_LENGTH: max_length = i_cfg_data;
                    default: ;
                endcase
            end
            // results always belong to earlier words, so check before predicting
            if (i_chunk.valid && i_chunk.ready) begin
                if (chunk_ends_q.size() == 0) begin
                    fails++;
                    $display("%0t unexpected chunk end: expected none, actual len %0d kind %0d",
                             $time, i_chunk.chunk_length, i_chunk.cut_kind);
                end else begin
                    want = chunk_ends_q.pop_front();
                    if (i_chunk.chunk_length !== want.length) begin
                        fails++;
                        $display("%0t chunk_length mismatch: expected %0d, actual %0d",
                                 $time, want.length, i_chunk.chunk_length);
                    end
                    if (i_chunk.cut_kind !== want.kind) begin
                        fails++;
                        $display("%0t cut_kind mismatch: expected %0d, actual %0d",
                                 $time, want.kind, i_chunk.cut_kind);
                    end
                end
            end
            if (i_data.valid && i_data.ready) begin
                if (advance_stream(t_action'(i_data.action), i_data.data_byte,
                                   i_data.table_index, i_data.table_word, cut))
                    chunk_ends_q.push_back(cut);
            end
        end
        o_fail_count <= fails;
        o_pending    <= chunk_ends_q.size();
    end

endmodule

// File: tb/sv/gear_hash_chunk_boundary_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gear_hash_chunk_boundary_tb: regression bench for the gear-hash chunker
// Fills the gear table, runs a short directed set of corner cases, then many
// random phases under different mask/limit settings with bursty input and a
// stalling result sink. A side checker predicts and compares every word.
// ----------------------------------------------------------------------------
module gear_hash_chunk_boundary_tb;
    import ghcb_pkg::*;

    localparam int CLK_HALF     = 5;     // 10 ns period
    localparam int RST_CYCLES   = 11;
    localparam int WORD_TARGET  = 1300;  // counted words, dropped action 3 excluded
    // Quiet time before a config write: front register + 4-deep queue +
    // table-read and lane-update stages can still hold words that end no chunk.
    localparam int DRAIN_CYCLES = 16;
    // Longest honest quiet stretch is a sender gap plus a sink stall; this is
    // far beyond that.
    localparam int IDLE_LIMIT   = 2000;

    // receiver behavior, switched at random between the modes below
    typedef enum {
        RX_OPEN,      // always ready
        RX_COIN,      // ready half the time
        RX_CHOKE,     // ready with a one-in-four chance
        RX_PERIODIC   // ready follows bit 3 of a tick counter
    } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending_chunks;
    int burst_left;
    int words_sent;
    int idle_cycles;

    ghcb_in_if  data_ch ();
    ghcb_out_if chunk_ch ();

    gear_hash_chunk_boundary u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (data_ch),
        .o_chunk    (chunk_ch)
    );

    ghcb_chunk_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_data       (data_ch),
        .i_chunk      (chunk_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_chunks)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog: any handshake or config write counts as progress.
    always @(posedge i_clk) begin
        if ((data_ch.valid && data_ch.ready) || (chunk_ch.valid && chunk_ch.ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("gear_hash_chunk_boundary regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink: mode switches at random so stalls land on every pipe phase,
    // with open stretches in between.
    initial begin
        t_rx_mode    mode;
        int          run;
        int unsigned tick;
        chunk_ch.ready = 1'b0;
        mode = RX_OPEN;
        run  = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                run  = $urandom_range(16, 160);
            end else begin
                run--;
            end
            tick++;
            case (mode)
                RX_OPEN:  chunk_ch.ready <= 1'b1;
                RX_COIN:  chunk_ch.ready <= 1'($urandom);
                RX_CHOKE: chunk_ch.ready <= ($urandom_range(0, 3) == 0);
                default:  chunk_ch.ready <= tick[3];
            endcase
        end
    end

    // Send one word. Bursts of random length, random gaps between them; valid
    // stays high across back-to-back words inside a burst.
    task automatic send_word(input t_action act, input logic [BYTE_W-1:0] dbyte,
                             input logic [BYTE_W-1:0] tidx, input logic [GEAR_W-1:0] tword);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                data_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        data_ch.valid       <= 1'b1;
        data_ch.action      <= act;
        data_ch.data_byte   <= dbyte;
        data_ch.table_index <= tidx;
        data_ch.table_word  <= tword;
        @(posedge i_clk);
        while (!data_ch.ready) @(posedge i_clk);
        burst_left--;
        if (act != ACT_NONE) words_sent++;
    endtask

    // Stop sending, wait for every predicted chunk end, then let the pipe
    // flush words that end no chunk.
    task automatic settle();
        data_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);   // checker's count is registered
        while (pending_chunks != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers written on consecutive edges; block must be idle.
    task automatic apply_settings(input logic [MASK_W-1:0] mask_sel,
                                  input logic [LEN_W-1:0] length_sel);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MASK_BITS;
        i_cfg_data <= CFG_DATA_W'(mask_sel);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_LENGTH;
        i_cfg_data <= length_sel;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        t_action           act;
        logic [MASK_W-1:0] mask_sel;
        logic [LEN_W-1:0]  length_sel;
        logic [GEAR_W-1:0] gear_word;
        int                phase_words;
        int                pick;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        data_ch.valid       = 1'b0;
        data_ch.action      = ACT_NONE;
        data_ch.data_byte   = '0;
        data_ch.table_index = '0;
        data_ch.table_word  = '0;
        burst_left          = 0;
        words_sent          = 0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty tail right out of reset, and a dropped action-3 word with all
        // fields at their top values. Neither may produce a result.
        send_word(ACT_EOS, 8'h00, 8'h00, 32'h0000_0000);
        send_word(ACT_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);

        // Fill the whole gear table before any data byte. A few entries are
        // pinned so the directed words below hit known hash values.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (i)
                0:       gear_word = 32'h0000_0000;
                1:       gear_word = 32'h0000_0001;
                255:     gear_word = 32'hFFFF_FFFF;
                default: gear_word = $urandom;
            endcase
            send_word(ACT_LOAD, 8'($urandom), 8'(i), gear_word);
        end

        // --- directed corner cases ---

        // Empty mask: every byte closes a one-byte chunk.
        settle();
        apply_settings(5'd0, 17'd5);
        send_word(ACT_BYTE, 8'h00, 8'h00, 32'h0);
        send_word(ACT_BYTE, 8'hFF, 8'h00, 32'h0);

        // Limit of one: an odd gear word matches on the limit byte (hash wins),
        // a zero gear word gives a plain limit cut.
        settle();
        apply_settings(5'd1, 17'd1);
        send_word(ACT_BYTE, 8'h01, 8'h00, 32'h0);
        send_word(ACT_BYTE, 8'h00, 8'h00, 32'h0);

        // Widest mask: all-ones word matches at once; then a table load in the
        // middle of a chunk, a tail, an empty tail and a dropped word.
        settle();
        apply_settings(5'd31, 17'd3);
        send_word(ACT_BYTE, 8'hFF, 8'h00, 32'h0);
        send_word(ACT_BYTE, 8'h00, 8'h00, 32'h0);
        send_word(ACT_LOAD, 8'h00, 8'h02, $urandom);
        send_word(ACT_BYTE, 8'h00, 8'h00, 32'h0);
        send_word(ACT_EOS, 8'h00, 8'h00, 32'h0);
        send_word(ACT_EOS, 8'h00, 8'h00, 32'h0);
        send_word(ACT_NONE, 8'($urandom), 8'($urandom), $urandom);

        // Zero limit behaves as one.
        settle();
        apply_settings(5'd4, 17'd0);
        send_word(ACT_BYTE, 8'($urandom), 8'h00, 32'h0);
        send_word(ACT_BYTE, 8'($urandom), 8'h00, 32'h0);

        // Limit above the largest chunk clamps; tail closes the stream.
        settle();
        apply_settings(MASK_BITS_RST, 17'h1FFFF);
        send_word(ACT_BYTE, 8'h80, 8'h00, 32'h0);
        send_word(ACT_BYTE, 8'h7F, 8'h00, 32'h0);
        send_word(ACT_EOS, 8'h00, 8'h00, 32'h0);

        // --- random phases ---
        // Mostly small masks and short limits so chunk ends come often; now and
        // then the extremes and fully random register values.
        while (words_sent < WORD_TARGET) begin
            settle();
            pick = $urandom_range(0, 9);
            if (pick < 6)       mask_sel = 5'($urandom_range(1, 6));
            else if (pick == 6) mask_sel = 5'd0;
            else if (pick == 7) mask_sel = 5'd31;
            else                mask_sel = 5'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 6)       length_sel = 17'($urandom_range(1, 48));
            else if (pick == 6) length_sel = 17'd0;
            else if (pick == 7) length_sel = 17'(MAX_CHUNK);
            else if (pick == 8) length_sel = 17'h1FFFF;
            else                length_sel = 17'($urandom);
            apply_settings(mask_sel, length_sel);

            phase_words = $urandom_range(30, 150);
            repeat (phase_words) begin
                pick = $urandom_range(0, 99);
                if (pick < 84)      act = ACT_BYTE;
                else if (pick < 92) act = ACT_EOS;
                else if (pick < 97) act = ACT_LOAD;
                else                act = ACT_NONE;
                // table reloads sometimes use all-zero / all-ones words
                gear_word = $urandom;
                if ($urandom_range(0, 7) == 0)
                    gear_word = pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
                send_word(act, 8'($urandom), 8'($urandom), gear_word);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("gear_hash_chunk_boundary regression: pass");
        end else begin
            $display("gear_hash_chunk_boundary regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/ghcb_pkg.sv
sv/ghcb_in_if.sv
sv/ghcb_out_if.sv
sv/ghcb_front.sv
sv/ghcb_queue.sv
sv/ghcb_back.sv
sv/gear_hash_chunk_boundary.sv
tb/sv/ghcb_chunk_checker.sv
tb/sv/gear_hash_chunk_boundary_tb.sv
